FILE: design/bfc_pkg.sv
// Shared types and constants for the bfloat16 / float32 converter.
// No dependencies; used by every module of the block.
package bfc_pkg;

	localparam int unsigned CFG_DATA_W = 3;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FP_PRESENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DYN_RM     = 1'd1;

	localparam logic [2:0] RM_RNE  = 3'd0;
	localparam logic [2:0] RM_RTZ  = 3'd1;
	localparam logic [2:0] RM_RDN  = 3'd2;
	localparam logic [2:0] RM_RUP  = 3'd3;
	localparam logic [2:0] RM_RMM  = 3'd4;
	localparam logic [2:0] RM_RSV5 = 3'd5;
	localparam logic [2:0] RM_RSV6 = 3'd6;
	localparam logic [2:0] RM_DYN  = 3'd7;

	localparam logic ACT_NARROW = 1'b0;
	localparam logic ACT_WIDEN  = 1'b1;

	localparam logic [31:0] CANON_NAN32 = 32'h7FC0_0000;
	localparam logic [31:0] BOX32_TAG   = 32'hFFFF_FFFF;
	localparam logic [47:0] BOX16_TAG   = 48'hFFFF_FFFF_FFFF;
	localparam logic [7:0]  EXP_ONES    = 8'hFF;

	localparam int unsigned FLAG_INVALID_BIT  = 4;
	localparam int unsigned FLAG_OVERFLOW_BIT = 2;
	localparam int unsigned FLAG_INEXACT_BIT  = 0;

	typedef struct packed {
		logic        action;
		logic [63:0] source_value;
		logic [2:0]  round_mode;
	} in_t;

	typedef struct packed {
		logic [63:0] result_value;
		logic        illegal;
		logic [4:0]  flags_raised;
	} out_t;

	typedef struct packed {
		logic       fp_present;
		logic [2:0] dynamic_round_mode;
	} cfg_t;

endpackage

FILE: design/bf16_fp32_converter.sv
// Top level of the bfloat16 / float32 converter; uses bfc_pkg, bfc_cfg_regs
// and bfc_convert.
//
// Converts one NaN-boxed operand per word: float32 to bfloat16 with five
// rounding modes, or bfloat16 to float32, returning the NaN-boxed result, an
// illegal-instruction indication and the invalid, overflow and inexact flags.
// The block takes one word every cycle while in_stall is low. Each word passes
// through the input register and then the result register, with the whole
// conversion done in the logic between them. A stalled output holds its word
// while the input register keeps accepting until it is also occupied. Write
// configuration only while no word is in flight.
module bf16_fp32_converter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  bfc_pkg::in_t                      in_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output bfc_pkg::out_t                     out_word,
	input  logic                              cfg_we,
	input  logic [bfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	bfc_pkg::cfg_t cfg;
	bfc_pkg::in_t  word_s1;
	logic          valid_s1;
	bfc_pkg::out_t res_s2;
	logic          valid_s2;
	bfc_pkg::out_t conv;
	logic          s2_ready;
	logic          s1_ready;

	bfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bfc_convert u_conv (
		.in_word (word_s1),
		.cfg     (cfg),
		.res     (conv)
	);

	assign s2_ready = !valid_s2 || !out_stall;
	assign s1_ready = !valid_s1 || s2_ready;
	assign in_stall = !s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			word_s1 <= in_word;
		end
		if (s2_ready && valid_s1) begin
			res_s2 <= conv;
		end
	end

	assign out_valid = valid_s2;
	assign out_word  = res_s2;

endmodule

FILE: design/bfc_cfg_regs.sv
// Configuration registers of the converter: FP enable and dynamic rounding mode.
// Depends on bfc_pkg.
module bfc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output bfc_pkg::cfg_t                     cfg
);

	bfc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fp_present         <= 1'b1;
			cfg_q.dynamic_round_mode <= bfc_pkg::RM_RNE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bfc_pkg::CFG_FP_PRESENT: cfg_q.fp_present <= cfg_data[0];
				bfc_pkg::CFG_DYN_RM:     cfg_q.dynamic_round_mode <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/bfc_convert.sv
// Conversion datapath: legality check, NaN-box unpacking, widening and
// rounded narrowing of one word. Depends on bfc_pkg.
module bfc_convert (
	input  bfc_pkg::in_t  in_word,
	input  bfc_pkg::cfg_t cfg,
	output bfc_pkg::out_t res
);

	logic        illegal;
	logic [2:0]  mode;
	logic [63:0] src;

	logic [15:0] h;
	logic        boxed16;
	logic        nan16;
	logic [31:0] wide_v;
	logic        wide_inv;

	logic [31:0] x;
	logic        boxed32;
	logic        nan32;
	logic [31:0] nv;
	logic        narrow_inv;
	logic        lsb;
	logic        grd;
	logic        stk;
	logic        inc;
	logic [15:0] rsum;
	logic        ovf;
	logic        inexact;

	always_comb begin
		src = in_word.source_value;
		illegal = !cfg.fp_present
			|| in_word.round_mode == bfc_pkg::RM_RSV5
			|| in_word.round_mode == bfc_pkg::RM_RSV6
			|| (in_word.round_mode == bfc_pkg::RM_DYN && cfg.dynamic_round_mode > bfc_pkg::RM_RMM);
		mode = (in_word.round_mode == bfc_pkg::RM_DYN) ? cfg.dynamic_round_mode
			: in_word.round_mode;

		h        = src[15:0];
		boxed16  = src[63:16] == bfc_pkg::BOX16_TAG;
		nan16    = h[14:7] == bfc_pkg::EXP_ONES && h[6:0] != 7'd0;
		wide_inv = boxed16 && nan16 && !h[6];
		wide_v   = (!boxed16 || nan16) ? bfc_pkg::CANON_NAN32 : {h, 16'h0000};

		x          = src[31:0];
		boxed32    = src[63:32] == bfc_pkg::BOX32_TAG;
		nan32      = x[30:23] == bfc_pkg::EXP_ONES && x[22:0] != 23'd0;
		narrow_inv = boxed32 && nan32 && !x[22];
		nv         = (!boxed32 || nan32) ? bfc_pkg::CANON_NAN32 : x;

		lsb = nv[16];
		grd = nv[15];
		stk = |nv[14:0];
		unique case (mode)
			bfc_pkg::RM_RNE: inc = grd && (lsb || stk);
			bfc_pkg::RM_RTZ: inc = 1'b0;
			bfc_pkg::RM_RDN: inc = (grd || stk) && nv[31];
			bfc_pkg::RM_RUP: inc = (grd || stk) && !nv[31];
			bfc_pkg::RM_RMM: inc = grd;
			default:         inc = 1'b0;
		endcase
		rsum    = nv[31:16] + {15'h0000, inc};
		ovf     = inc && rsum[14:7] == bfc_pkg::EXP_ONES && nv[30:23] != bfc_pkg::EXP_ONES;
		inexact = grd || stk || ovf;

		res = '0;
		if (illegal) begin
			res.illegal = 1'b1;
		end else if (in_word.action == bfc_pkg::ACT_WIDEN) begin
			res.result_value = {bfc_pkg::BOX32_TAG, wide_v};
			res.flags_raised[bfc_pkg::FLAG_INVALID_BIT] = wide_inv;
		end else begin
			res.result_value = {bfc_pkg::BOX16_TAG, rsum};
			res.flags_raised[bfc_pkg::FLAG_INVALID_BIT]  = narrow_inv;
			res.flags_raised[bfc_pkg::FLAG_OVERFLOW_BIT] = ovf;
			res.flags_raised[bfc_pkg::FLAG_INEXACT_BIT]  = inexact;
		end
	end

endmodule

FILE: design/bfc_checker.sv
// Port-level checks for the converter, bound to bf16_fp32_converter.
// Depends on bfc_pkg.
module bfc_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  bfc_pkg::out_t                     out_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output word changed");

	a_illegal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.illegal |->
			out_word.result_value == 64'd0 && out_word.flags_raised == 5'd0)
		else $error("illegal word carries a result or flags");

	a_boxed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.illegal |-> out_word.result_value[63:32] == bfc_pkg::BOX32_TAG)
		else $error("result is not NaN-boxed");

	a_ovf_inexact: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.flags_raised[bfc_pkg::FLAG_OVERFLOW_BIT] |->
			out_word.flags_raised[bfc_pkg::FLAG_INEXACT_BIT]
			&& out_word.result_value[63:16] == bfc_pkg::BOX16_TAG)
		else $error("overflow without inexact or on a widening");

	a_unused_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.flags_raised[3] == 1'b0 && out_word.flags_raised[1] == 1'b0)
		else $error("unsupported flag raised");

endmodule

bind bf16_fp32_converter bfc_checker u_bfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

FILE: bench/bfc_checker.sv
// Scoreboard for the bfloat16 / float32 converter: watches the input, output and
// configuration ports, predicts each result word and compares it field by field.
// Depends on bfc_pkg for the word types, rounding modes and flag positions.
module bfc_scoreboard (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  bfc_pkg::in_t                   in_word,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  bfc_pkg::out_t                  out_word,
	input  logic                           cfg_we,
	input  logic [bfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bfc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                    words_in_flight,
	output int unsigned                    mismatches
);

	bfc_pkg::cfg_t cfg;
	bfc_pkg::out_t conversions_due[$];

	function automatic bfc_pkg::out_t convert_word(bfc_pkg::in_t w, bfc_pkg::cfg_t c);
		bfc_pkg::out_t r;
		logic [2:0]    mode;
		logic [31:0]   f32;
		logic [15:0]   b16;
		logic          grd;
		logic          stk;
		logic          up;
		r = '0;
		if (!c.fp_present || w.round_mode == bfc_pkg::RM_RSV5 ||
				w.round_mode == bfc_pkg::RM_RSV6 ||
				(w.round_mode == bfc_pkg::RM_DYN && c.dynamic_round_mode > bfc_pkg::RM_RMM)) begin
			r.illegal = 1'b1;
			return r;
		end
		mode = (w.round_mode == bfc_pkg::RM_DYN) ? c.dynamic_round_mode : w.round_mode;
		if (w.action == bfc_pkg::ACT_WIDEN) begin
			b16 = w.source_value[15:0];
			if (w.source_value[63:16] != bfc_pkg::BOX16_TAG) begin
				f32 = bfc_pkg::CANON_NAN32;
			end else if (b16[14:7] == bfc_pkg::EXP_ONES && b16[6:0] != '0) begin
				if (!b16[6])
					r.flags_raised[bfc_pkg::FLAG_INVALID_BIT] = 1'b1;
				f32 = bfc_pkg::CANON_NAN32;
			end else begin
				f32 = {b16, 16'h0000};
			end
			r.result_value = {bfc_pkg::BOX32_TAG, f32};
		end else begin
			f32 = w.source_value[31:0];
			if (w.source_value[63:32] != bfc_pkg::BOX32_TAG) begin
				f32 = bfc_pkg::CANON_NAN32;
			end else if (f32[30:23] == bfc_pkg::EXP_ONES && f32[22:0] != '0) begin
				if (!f32[22])
					r.flags_raised[bfc_pkg::FLAG_INVALID_BIT] = 1'b1;
				f32 = bfc_pkg::CANON_NAN32;
			end
			grd = f32[15];
			stk = |f32[14:0];
			up = 1'b0;
			if (grd || stk) begin
				r.flags_raised[bfc_pkg::FLAG_INEXACT_BIT] = 1'b1;
				case (mode)
					bfc_pkg::RM_RNE: up = grd && (f32[16] || stk);
					bfc_pkg::RM_RDN: up = f32[31];
					bfc_pkg::RM_RUP: up = !f32[31];
					bfc_pkg::RM_RMM: up = grd;
					default: up = 1'b0;
				endcase
			end
			b16 = f32[31:16];
			if (up) begin
				b16 = b16 + 16'd1;
				if (b16[14:7] == bfc_pkg::EXP_ONES && f32[30:23] != bfc_pkg::EXP_ONES) begin
					r.flags_raised[bfc_pkg::FLAG_OVERFLOW_BIT] = 1'b1;
					r.flags_raised[bfc_pkg::FLAG_INEXACT_BIT] = 1'b1;
				end
			end
			r.result_value = {bfc_pkg::BOX16_TAG, b16};
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bfc_pkg::out_t want;
		int unsigned   bad;
		if (!arst_n) begin
			cfg.fp_present <= 1'b1;
			cfg.dynamic_round_mode <= bfc_pkg::RM_RNE;
			conversions_due.delete();
			words_in_flight <= 0;
			mismatches <= 0;
		end else begin
			bad = 0;
			if (out_valid && !out_stall) begin
				if (conversions_due.size() == 0) begin
					$display("%0t: result word %h arrived with nothing outstanding",
						$time, out_word);
					bad++;
				end else begin
					want = conversions_due.pop_front();
					if (out_word.result_value !== want.result_value) begin
						$display("%0t: result_value expected %h actual %h",
							$time, want.result_value, out_word.result_value);
						bad++;
					end
					if (out_word.illegal !== want.illegal) begin
						$display("%0t: illegal expected %b actual %b",
							$time, want.illegal, out_word.illegal);
						bad++;
					end
					if (out_word.flags_raised !== want.flags_raised) begin
						$display("%0t: flags_raised expected %b actual %b",
							$time, want.flags_raised, out_word.flags_raised);
						bad++;
					end
				end
			end
			if (in_valid && !in_stall)
				conversions_due.push_back(convert_word(in_word, cfg));
			if (cfg_we) begin
				case (cfg_index)
					bfc_pkg::CFG_FP_PRESENT: cfg.fp_present <= cfg_data[0];
					bfc_pkg::CFG_DYN_RM: cfg.dynamic_round_mode <= cfg_data;
					default: ;
				endcase
			end
			words_in_flight <= conversions_due.size();
			mismatches <= mismatches + bad;
		end
	end

endmodule

FILE: bench/tb_bf16_fp32_converter.sv
// Top of the converter testbench: clock, reset, directed and random conversion
// words, random back-pressure and the final verdict.
// Depends on bfc_pkg, bf16_fp32_converter and the bfc_scoreboard module.
module tb_bf16_fp32_converter;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	bfc_pkg::in_t                   in_word;
	logic                           out_valid;
	logic                           out_stall;
	bfc_pkg::out_t                  out_word;
	logic                           cfg_we;
	logic [bfc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bfc_pkg::CFG_DATA_W-1:0] cfg_data;
	int unsigned                    words_in_flight;
	int unsigned                    mismatches;
	bit                             calm;
	bit                             hold_req;

	bf16_fp32_converter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bfc_scoreboard u_scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_word         (in_word),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_word        (out_word),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.words_in_flight (words_in_flight),
		.mismatches      (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic bfc_pkg::in_t make_word(logic act, logic [63:0] src, logic [2:0] rm);
		bfc_pkg::in_t w;
		w.action = act;
		w.source_value = src;
		w.round_mode = rm;
		return w;
	endfunction

	function automatic bfc_pkg::in_t random_word();
		bfc_pkg::in_t w;
		logic [31:0]  body;
		int unsigned  pick;
		w.action = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 15);
		if (pick < 10)
			w.round_mode = 3'(pick % 5);
		else if (pick < 13)
			w.round_mode = bfc_pkg::RM_DYN;
		else
			w.round_mode = 3'($urandom_range(5, 6));
		body = $urandom;
		case ($urandom_range(0, 7))
			0: body[30:23] = bfc_pkg::EXP_ONES;
			1: body[30:16] = {8'hFE, 7'h7F};
			2: body[30:23] = 8'h00;
			3: body[15:0] = 16'h8000;
			4: body[14:0] = 15'h0000;
			default: ;
		endcase
		if (w.action == bfc_pkg::ACT_WIDEN)
			w.source_value = {bfc_pkg::BOX16_TAG, body[31:16]};
		else
			w.source_value = {bfc_pkg::BOX32_TAG, body};
		pick = $urandom_range(0, 9);
		if (pick == 0)
			w.source_value = {$urandom, $urandom};
		else if (pick == 1)
			w.source_value[6'($urandom_range(w.action == bfc_pkg::ACT_WIDEN ? 16 : 32, 63))]
				^= 1'b1;
		return w;
	endfunction

	task automatic send(bfc_pkg::in_t w);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_in_flight != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(logic fp, logic [2:0] dyn);
		cfg_we <= 1'b1;
		cfg_index <= bfc_pkg::CFG_FP_PRESENT;
		cfg_data <= bfc_pkg::CFG_DATA_W'(fp);
		@(posedge clk);
		cfg_index <= bfc_pkg::CFG_DYN_RM;
		cfg_data <= dyn;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver: random stall per word, one long hold on request
	initial begin
		int unsigned n;
		bit          held;
		held = 1'b0;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				out_stall <= 1'b1;
				repeat (80) @(posedge clk);
				held = 1'b1;
				n = 0;
			end else begin
				n = calm ? 0 : $urandom_range(0, 6);
			end
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		logic        fp_tab[10];
		logic [2:0]  dyn_tab[10];
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		cfg_we <= 1'b0;
		cfg_index <= bfc_pkg::CFG_FP_PRESENT;
		cfg_data <= '0;
		calm = 1'b0;
		hold_req = 1'b0;
		fp_tab = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
		dyn_tab = '{bfc_pkg::RM_RNE, bfc_pkg::RM_RMM, bfc_pkg::RM_DYN, bfc_pkg::RM_RDN,
			bfc_pkg::RM_RUP, bfc_pkg::RM_RTZ, bfc_pkg::RM_RSV5, bfc_pkg::RM_RSV6,
			bfc_pkg::RM_RNE, bfc_pkg::RM_RMM};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_0000_0000, bfc_pkg::RM_RNE));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_8000_0000, bfc_pkg::RM_RUP));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_7F7F_FFFF, bfc_pkg::RM_RNE));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_7F7F_FFFF, bfc_pkg::RM_RTZ));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_FF7F_FFFF, bfc_pkg::RM_RDN));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_FF7F_FFFF, bfc_pkg::RM_RUP));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_7F80_0001, bfc_pkg::RM_RNE));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_7FC0_0000, bfc_pkg::RM_RMM));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_7F80_0000, bfc_pkg::RM_RNE));
		send(make_word(bfc_pkg::ACT_NARROW, 64'h0000_0000_3F80_0000, bfc_pkg::RM_RNE));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_3F80_8000, bfc_pkg::RM_RNE));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_3F81_8000, bfc_pkg::RM_RNE));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_3F80_8000, bfc_pkg::RM_RMM));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_0000_0001, bfc_pkg::RM_RUP));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_BF80_7FFF, bfc_pkg::RM_DYN));
		send(make_word(bfc_pkg::ACT_WIDEN, 64'hFFFF_FFFF_FFFF_7F81, bfc_pkg::RM_RNE));
		send(make_word(bfc_pkg::ACT_WIDEN, 64'hFFFF_FFFF_FFFF_7FC0, bfc_pkg::RM_RTZ));
		send(make_word(bfc_pkg::ACT_WIDEN, 64'hFFFF_FFFF_FFFF_FF80, bfc_pkg::RM_RDN));
		send(make_word(bfc_pkg::ACT_WIDEN, 64'hFFFF_FFFF_FFFF_8001, bfc_pkg::RM_RMM));
		send(make_word(bfc_pkg::ACT_WIDEN, 64'h0000_FFFF_FFFF_3F80, bfc_pkg::RM_RNE));
		send(make_word(bfc_pkg::ACT_WIDEN, 64'hFFFF_FFFF_FFFF_3F80, bfc_pkg::RM_RSV5));
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_3F80_0000, bfc_pkg::RM_RSV6));
		drain();
		set_regs(1'b1, bfc_pkg::RM_DYN);
		send(make_word(bfc_pkg::ACT_NARROW, 64'hFFFF_FFFF_3F80_0001, bfc_pkg::RM_DYN));
		send(make_word(bfc_pkg::ACT_WIDEN, 64'hFFFF_FFFF_FFFF_3F80, bfc_pkg::RM_RUP));
		drain();
		set_regs(1'b0, bfc_pkg::RM_RNE);
		send(make_word(bfc_pkg::ACT_WIDEN, 64'hFFFF_FFFF_FFFF_3F80, bfc_pkg::RM_RNE));
		drain();

		for (int p = 0; p < 10; p++) begin
			set_regs(fp_tab[p], dyn_tab[p]);
			calm = (p == 2);
			for (int i = 0; i < 145; i++) begin
				if (p == 3 && i == 20)
					hold_req = 1'b1;
				send(random_word());
			end
			drain();
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
design/bfc_pkg.sv
design/bfc_cfg_regs.sv
design/bfc_convert.sv
design/bf16_fp32_converter.sv
design/bfc_checker.sv
bench/bfc_checker.sv
bench/tb_bf16_fp32_converter.sv
